/* sv/nsf_pkg.sv */
package nsf_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [7:0] LENGTH_LIMIT_RESET = 8'd82;
  localparam logic [7:0] COUNT_MAX          = 8'd255;
  localparam logic [2:0] TYPE_LEN           = 3'd5;

  localparam logic [1:0] TYPE_OTHER = 2'd0;
  localparam logic [1:0] TYPE_GGA   = 2'd1;
  localparam logic [1:0] TYPE_GSA   = 2'd2;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic [7:0] field_index;
    logic       field_end;
    logic       sentence_end;
    logic       sentence_ok;
    logic [1:0] sentence_type;
    logic       aborted;
  } nsf_result_t;

  // Expected characters of "GPGGA" and "GPGSA" at each position of field 0.
  function automatic logic [7:0] gga_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h47;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] gsa_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h47;
      3'd3:    c = 8'h53;
      3'd4:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Returns {is_hex, nibble}; either letter case is taken.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* sv/nsf_parse_core.sv */
module nsf_parse_core
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output nsf_result_t result
);

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_FIELDS = 2'd1,
    MODE_CHECK  = 2'd2
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] length_limit;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] field_number, field_number_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] received_sum, received_sum_next;
  logic       hex_stopped, hex_stopped_next;
  logic [2:0] type_position, type_position_next;
  logic [1:0] type_match, type_match_next;

  logic [7:0] count_inc;
  logic [7:0] field_inc;
  logic [4:0] hex;

  assign count_inc = (byte_count == COUNT_MAX) ? byte_count : byte_count + 8'd1;
  assign field_inc = (field_number == COUNT_MAX) ? field_number : field_number + 8'd1;
  assign hex       = hex_value(rx_byte);

  always_comb begin
    result             = '0;
    mode_next          = mode;
    byte_count_next    = byte_count;
    field_number_next  = field_number;
    running_xor_next   = running_xor;
    received_sum_next  = received_sum;
    hex_stopped_next   = hex_stopped;
    type_position_next = type_position;
    type_match_next    = type_match;

    unique case (mode)
      MODE_FIELDS, MODE_CHECK: begin
        result.field_index = field_number;
        byte_count_next    = count_inc;
        if (count_inc >= length_limit) begin
          result.aborted = 1'b1;
          mode_next      = MODE_WAIT;
        end else if (mode == MODE_FIELDS) begin
          if (rx_byte == CHAR_COMMA || rx_byte == CHAR_STAR) begin
            result.field_end  = 1'b1;
            field_number_next = field_inc;
            if (rx_byte == CHAR_STAR) begin
              mode_next = MODE_CHECK;
            end else begin
              running_xor_next = running_xor ^ rx_byte;
            end
          end else begin
            result.char_valid = 1'b1;
            result.char_out   = rx_byte;
            running_xor_next  = running_xor ^ rx_byte;
            if (field_number == 8'd0) begin
              if (type_position < TYPE_LEN) begin
                type_match_next[0] = type_match[0] && (rx_byte == gga_char(type_position));
                type_match_next[1] = type_match[1] && (rx_byte == gsa_char(type_position));
                type_position_next = type_position + 3'd1;
              end else begin
                // A sixth character in field 0 rules out both types.
                type_match_next = 2'b00;
              end
            end
          end
        end else begin
          if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
            result.sentence_end = 1'b1;
            result.sentence_ok  = (received_sum == running_xor) && (field_number >= 8'd2);
            if (type_position == TYPE_LEN) begin
              if (type_match[0]) begin
                result.sentence_type = TYPE_GGA;
              end else if (type_match[1]) begin
                result.sentence_type = TYPE_GSA;
              end else begin
                result.sentence_type = TYPE_OTHER;
              end
            end
            mode_next = MODE_WAIT;
          end else if (!hex_stopped) begin
            if (hex[4]) begin
              received_sum_next = {received_sum[3:0], hex[3:0]};
            end else begin
              hex_stopped_next = 1'b1;
            end
          end
        end
      end
      default: begin
        mode_next = MODE_WAIT;
        if (rx_byte == CHAR_DOLLAR) begin
          mode_next          = MODE_FIELDS;
          byte_count_next    = 8'd0;
          field_number_next  = 8'd0;
          running_xor_next   = 8'd0;
          received_sum_next  = 8'd0;
          hex_stopped_next   = 1'b0;
          type_position_next = 3'd0;
          type_match_next    = 2'b11;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_WAIT;
      length_limit  <= LENGTH_LIMIT_RESET;
      byte_count    <= 8'd0;
      field_number  <= 8'd0;
      running_xor   <= 8'd0;
      received_sum  <= 8'd0;
      hex_stopped   <= 1'b0;
      type_position <= 3'd0;
      type_match    <= 2'b11;
    end else begin
      if (cfg_we) begin
        length_limit <= cfg_data;
      end
      if (step) begin
        mode          <= mode_next;
        byte_count    <= byte_count_next;
        field_number  <= field_number_next;
        running_xor   <= running_xor_next;
        received_sum  <= received_sum_next;
        hex_stopped   <= hex_stopped_next;
        type_position <= type_position_next;
        type_match    <= type_match_next;
      end
    end
  end

endmodule

/* sv/nsf_out_fifo.sv */
module nsf_out_fifo
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  nsf_result_t push_data,
  output logic        has_space,
  output logic        pop_valid,
  input  logic        pop_ready,
  output nsf_result_t pop_data
);

  nsf_result_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != 2'd0);
  assign has_space = (count != 2'd2);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* sv/nmea_sentence_stream_framer_unit.sv */
// A byte accepted on s_axis is held in an input register, then stepped through the parser
// into the result queue once the queue has space; m_axis presents beats from that queue.
// Throughput: one byte per cycle while the result queue has space; the parser keeps all
// its sentence state in registers and finishes every byte in one pass.
// A two-entry result queue keeps the input side moving while a beat waits downstream.
// Reset (rst, synchronous, active high) returns to waiting for '$' and length_limit to 82.
module nmea_sentence_stream_framer_unit
  import nsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] char_out, [15:8] field_index, [16] sentence_ok, [18:17] sentence_type,
  // [19] aborted, [23:20] zero
  output logic [23:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [0] char_valid, [1] field_end
  output logic        m_axis_tlast,  // sentence_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;
  logic        fifo_space;
  nsf_result_t step_result;
  nsf_result_t out_result;

  assign advance       = in_valid && fifo_space;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  nsf_parse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .step     (advance),
    .rx_byte  (in_byte),
    .result   (step_result)
  );

  nsf_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (step_result),
    .has_space (fifo_space),
    .pop_valid (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .pop_data  (out_result)
  );

  assign m_axis_tdata = {4'd0, out_result.aborted, out_result.sentence_type,
                         out_result.sentence_ok, out_result.field_index,
                         out_result.char_out};
  assign m_axis_tuser = {out_result.field_end, out_result.char_valid};
  assign m_axis_tlast = out_result.sentence_end;

endmodule

/* sv/nsf_checker.sv */
module nsf_checker
  import nsf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
    else $error("result beat changed while stalled");

  // A payload character is never also a delimiter.
  a_char_delim: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("char_valid and field_end together");

  // sentence_ok and a sentence type only come with the closing beat.
  a_ok_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[16] || m_axis_tdata[18:17] != TYPE_OTHER) |-> m_axis_tlast)
    else $error("sentence status without sentence_end");

  a_type_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[18:17] != 2'd3)
    else $error("bad sentence type code");

  // An aborted beat carries no character, delimiter or sentence end.
  a_abort: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[19] |-> !m_axis_tlast && m_axis_tuser == 2'b00
      && m_axis_tdata[7:0] == 8'd0)
    else $error("aborted beat carries other results");

endmodule

bind nmea_sentence_stream_framer_unit nsf_checker u_nsf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
